>>> hdl/rbm_pkg.sv
// rbm_pkg: command codes, status codes and channel payload types of the ring buffer.
// No dependencies; compiled first.
package rbm_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [CMD_W-1:0] CMD_PRELOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SOURCE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    // register index, taken from paddr[2]
    localparam logic REG_ROM_MODE      = 1'b0;
    localparam logic REG_ACCESS_PERIOD = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               in_flag;
        logic [VALUE_W-1:0] in_value;
    } t_in_item;

    typedef struct packed {
        logic                out_flag;
        logic [VALUE_W-1:0]  out_value;
        logic [STATUS_W-1:0] status;
    } t_out_item;

endpackage

>>> hdl/rbm_in_if.sv
// rbm_in_if: valid/ready channel carrying one command item.
// Depends on rbm_pkg.
interface rbm_in_if import rbm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

>>> hdl/rbm_out_if.sv
// rbm_out_if: valid/ready channel carrying one result item.
// Depends on rbm_pkg.
interface rbm_out_if import rbm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

>>> hdl/rbm_ram.sv
// rbm_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
module rbm_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ring_buffer_memory_rom_rwm.sv
// ring_buffer_memory_rom_rwm: top level of the flagged-word ring buffer.
// Depends on rbm_pkg, rbm_in_if, rbm_out_if and rbm_ram.
//
// Usage
//   i_cmd  : command transfers {cmd, in_flag, in_value}. cmd is preload push,
//            tick, source item or read.
//   o_res  : one result transfer {out_flag, out_value, status} per command.
//   APB    : rom_mode at 0x0, access_period at 0x4; write only while idle.
// Storage is a DEPTH-entry RAM holding {flag, data}; one slot stays empty, so
// at most DEPTH-1 entries are held. Head/tail pointers live in flops.
// Timing
//   preload, tick, source and empty read: result registered on the edge that
//   takes the command; the block is then ready for the next command.
//   non-empty read: the tail entry passes the RAM read register, then the
//   output register; no new command is taken while the read is in flight
//   (state S_READ). In ROM mode the popped entry is written back at the head
//   when it arrives from the RAM, as the result is registered.
// Stalls: the result sits in an output register. Outside a read, a new command
//   is taken while that register is empty or being drained in the same cycle.
// Reset (synchronous, active low): state, pointers, period counter, window and
//   the output valid flag clear; rom_mode -> 0, access_period -> 1. RAM contents
//   are not cleared.
module ring_buffer_memory_rom_rwm import rbm_pkg::*; #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rbm_in_if.sink            i_cmd,
    rbm_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned EW = DATA_WIDTH + 1;   // {flag, data}
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;   // RAM read of tail in flight

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    // control state
    logic                r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_tail, n_tail;
    logic [PERIOD_W-1:0] r_tick, n_tick;
    logic                r_window, n_window;
    logic                r_rom;
    logic [PERIOD_W-1:0] r_period;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    // RAM ports
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic          w_re;
    logic [EW-1:0] w_rdata;

    logic                w_out_free;
    logic                w_acc;
    logic                w_full;
    logic                w_empty;
    logic [PERIOD_W-1:0] w_period;
    logic [PERIOD_W:0]   w_tick_inc;
    logic                w_cfg_wr;

    rbm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_tail),
        .o_rdata (w_rdata)
    );

    // handshakes
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc       = i_cmd.valid && i_cmd.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign w_full     = (next_slot(r_head) == r_tail);
    assign w_empty    = (r_head == r_tail);
    assign w_period   = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign w_tick_inc = {1'b0, r_tick} + (PERIOD_W+1)'(1);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_tick      = r_tick;
        n_window    = r_window;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        w_we        = 1'b0;
        w_waddr     = r_head;
        w_wdata     = {i_cmd.data.in_flag, DATA_WIDTH'(i_cmd.data.in_value)};
        w_re        = 1'b0;

        if (r_state == S_READ) begin
            // popped entry arrives from RAM
            n_out.out_flag  = w_rdata[DATA_WIDTH];
            n_out.out_value = VALUE_W'(w_rdata[DATA_WIDTH-1:0]);
            n_out.status    = ST_DONE;
            n_out_valid     = 1'b1;
            n_tail          = next_slot(r_tail);
            // ROM: recirculate; the pop just freed a slot, so this never overflows
            if (r_rom) begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_head  = next_slot(r_head);
            end
            n_state = S_IDLE;
        end else if (w_acc) begin
            n_out       = '0;
            n_out.status = ST_DONE;
            n_out_valid = 1'b1;
            unique case (i_cmd.data.cmd)
                CMD_PRELOAD: begin
                    if (w_full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        w_we   = 1'b1;
                        n_head = next_slot(r_head);
                    end
                end
                CMD_TICK: begin
                    n_window = (r_tick == '0) && !r_rom;
                    n_tick   = (w_tick_inc >= {1'b0, w_period}) ? '0
                                                                 : w_tick_inc[PERIOD_W-1:0];
                end
                CMD_SOURCE: begin
                    priority if (!r_window) begin
                        n_out.status = ST_IGNORED;
                    end else if (!i_cmd.data.in_flag) begin
                        n_window = 1'b0;          // terminator closes the window
                    end else if (w_full) begin
                        n_window     = 1'b0;
                        n_out.status = ST_FULL;
                    end else begin
                        w_we   = 1'b1;
                        n_head = next_slot(r_head);
                    end
                end
                CMD_READ: begin
                    if (w_empty) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        w_re        = 1'b1;
                        n_out_valid = 1'b0;
                        n_state     = S_READ;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_tick      <= '0;
            r_window    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_tick      <= n_tick;
            r_window    <= n_window;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom    <= 1'b0;
            r_period <= PERIOD_W'(1);
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_ROM_MODE) begin
                r_rom <= pwdata[0];
            end else begin
                r_period <= pwdata[PERIOD_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ACCESS_PERIOD) begin
            prdata = APB_DW'(r_period);
        end else begin
            prdata = APB_DW'(r_rom);
        end
    end

endmodule

>>> hdl/rbm_checker.sv
// rbm_checker: port-level assertions for ring_buffer_memory_rom_rwm, bound to the top.
// Depends on rbm_pkg.
module rbm_checker import rbm_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cmd_valid,
    input logic             i_cmd_ready,
    input logic [CMD_W-1:0] i_cmd_code,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input t_out_item        i_res_data
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_data)))
        else $error("result dropped or changed while stalled");

    // non-read commands produce their result on the next cycle
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready && i_cmd_code != CMD_READ) |=> i_res_valid)
        else $error("missing result for non-read command");

    // a read answers directly (empty) or after the RAM read of the entry
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready && i_cmd_code == CMD_READ)
        |=> (i_res_valid or (##1 i_res_valid)))
        else $error("missing result for read command");

    // only a successful transfer carries entry data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_data.status != ST_DONE)
        |-> (!i_res_data.out_flag && i_res_data.out_value == '0))
        else $error("failed command returned entry data");

endmodule

bind ring_buffer_memory_rom_rwm rbm_checker u_rbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_cmd_code  (i_cmd.data.cmd),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
